// ===== sv/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Item types, command and event codes, and constant tables for the LCD
// init and refresh sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // input item commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_WRITE   = 2'd2;

  // result event kinds
  localparam logic [1:0] EV_BYTE       = 2'd0;
  localparam logic [1:0] EV_INIT_DONE  = 2'd1;
  localparam logic [1:0] EV_FRAME_DONE = 2'd2;

  localparam logic [7:0] CLEAR_CMD_RST = 8'h01;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic       link_ready;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] tx_byte;
    logic       register_select;
  } out_item_t;

  // controller init commands, zero past the listed bytes
  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h39;
      4'd1:    b = 8'h39;
      4'd2:    b = 8'h15;
      4'd3:    b = 8'h55;
      4'd4:    b = 8'h6E;
      4'd5:    b = 8'h72;
      4'd6:    b = 8'h38;
      4'd7:    b = 8'h0F;
      4'd8:    b = 8'h01;
      4'd9:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // power-up message text, spaces at the unlisted indices
  function automatic logic [7:0] default_char(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd1:    c = 8'h43; // C
      6'd2:    c = 8'h57; // W
      6'd5:    c = 8'h2D; // -
      6'd7:    c = 8'h32; // 2
      6'd8:    c = 8'h30; // 0
      6'd9:    c = 8'h2E; // .
      6'd10:   c = 8'h30; // 0
      6'd12:   c = 8'h43; // C
      6'd17:   c = 8'h30; // 0
      6'd18:   c = 8'h2E; // .
      6'd19:   c = 8'h32; // 2
      6'd21:   c = 8'h52; // R
      6'd22:   c = 8'h50; // P
      6'd23:   c = 8'h53; // S
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/lcd_init_and_refresh_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// lcd_init_and_refresh_sequencer_core
// Init and message refresh byte sequencer for a serial character LCD.
// Output: a result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while no result is held stalled; the store is read and written once per item
// on its single synchronous port, the result register frees as it is taken.
// Reset: synchronous, active low; starts busy in the init phase, store valid
// bits are cleared so unwritten entries read the power-up text, no sweep.
// ----------------------------------------------------------------------------
module lcd_init_and_refresh_sequencer_core #(
  parameter int MSG_LEN  = 24,
  parameter int INIT_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lcdseq_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdseq_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  localparam int AW  = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
  localparam int MPW = $clog2(MSG_LEN + 1);
  localparam int IPW = $clog2(INIT_LEN + 1);
  localparam logic [MPW-1:0] MSG_END  = MPW'(MSG_LEN);
  localparam logic [IPW-1:0] INIT_END = IPW'(INIT_LEN);

  // control state
  logic           init_phase_r, init_phase_nxt;
  logic           busy_r, busy_nxt;
  logic [IPW-1:0] init_pos_r, init_pos_nxt;
  logic [MPW-1:0] msg_pos_r, msg_pos_nxt;
  logic           sel_r, sel_nxt;
  logic [7:0]     clear_cmd_r;
  logic [7:0]     entry0_r, entry0_nxt;

  // message store, entry zero lives in entry0_r
  logic [7:0]         mem [MSG_LEN];
  logic [MSG_LEN-1:0] vld_r;
  logic [7:0]         mem_rd_r;

  // result register
  logic       out_valid_r;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       rs_r;
  logic       use_mem_r;

  logic           accept;
  logic           res_vld;
  logic [1:0]     res_kind;
  logic [7:0]     res_byte;
  logic           res_mem;
  logic           mem_we;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign wr_addr   = AW'(in_item.byte_index);
  assign rd_addr   = msg_pos_r[AW-1:0];
  assign mem_we    = accept && (in_item.cmd == lcdseq_pkg::CMD_WRITE)
                     && (32'(in_item.byte_index) < MSG_LEN);

  always_comb begin
    init_phase_nxt = init_phase_r;
    busy_nxt       = busy_r;
    init_pos_nxt   = init_pos_r;
    msg_pos_nxt    = msg_pos_r;
    sel_nxt        = sel_r;
    entry0_nxt     = entry0_r;
    res_vld        = 1'b0;
    res_kind       = lcdseq_pkg::EV_BYTE;
    res_byte       = 8'h00;
    res_mem        = 1'b0;
    if (accept) begin
      case (in_item.cmd)
        lcdseq_pkg::CMD_TICK: begin
          if (busy_r && in_item.link_ready) begin
            res_vld = 1'b1;
            if (init_phase_r) begin
              if (init_pos_r < INIT_END) begin
                res_byte     = lcdseq_pkg::init_byte(4'(init_pos_r));
                init_pos_nxt = init_pos_r + 1'b1;
              end else begin
                init_phase_nxt = 1'b0;
                busy_nxt       = 1'b0;
                res_kind       = lcdseq_pkg::EV_INIT_DONE;
              end
            end else if (msg_pos_r < MSG_END) begin
              // data from the second byte on
              if (msg_pos_r == MPW'(1)) begin
                sel_nxt = 1'b1;
              end
              if (msg_pos_r == '0) begin
                res_byte = entry0_r;
              end else begin
                res_byte = lcdseq_pkg::default_char(6'(msg_pos_r));
                res_mem  = vld_r[rd_addr];
              end
              msg_pos_nxt = msg_pos_r + 1'b1;
            end else begin
              msg_pos_nxt = '0;
              busy_nxt    = 1'b0;
              res_kind    = lcdseq_pkg::EV_FRAME_DONE;
            end
          end
        end
        lcdseq_pkg::CMD_REFRESH: begin
          if (!busy_r) begin
            sel_nxt  = 1'b0;
            busy_nxt = 1'b1;
          end
        end
        lcdseq_pkg::CMD_WRITE: begin
          entry0_nxt = clear_cmd_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_phase_r <= 1'b1;
      busy_r       <= 1'b1;
      init_pos_r   <= '0;
      msg_pos_r    <= '0;
      sel_r        <= 1'b0;
      clear_cmd_r  <= lcdseq_pkg::CLEAR_CMD_RST;
      entry0_r     <= lcdseq_pkg::CLEAR_CMD_RST;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      init_phase_r <= init_phase_nxt;
      busy_r       <= busy_nxt;
      init_pos_r   <= init_pos_nxt;
      msg_pos_r    <= msg_pos_nxt;
      sel_r        <= sel_nxt;
      entry0_r     <= entry0_nxt;
      if (cfg_valid && cfg_ready) begin
        clear_cmd_r <= cfg_data;
      end
      if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (accept) begin
        out_valid_r <= res_vld;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // store port: one write or one read per accepted item
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_item.byte_value;
    end
    if (accept && res_vld) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_vld) begin
      kind_r    <= res_kind;
      byte_r    <= res_byte;
      rs_r      <= sel_nxt;
      use_mem_r <= res_mem;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_item.event_kind      = kind_r;
  assign out_item.tx_byte         = use_mem_r ? mem_rd_r : byte_r;
  assign out_item.register_select = rs_r;

endmodule

// ===== sv/lcdseq_checker.sv =====
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks for the LCD init and refresh sequencer.
// ----------------------------------------------------------------------------
module lcdseq_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input lcdseq_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input logic                  out_stall,
  input lcdseq_pkg::out_item_t out_item
);

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // refresh and write items never make a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_item.cmd == lcdseq_pkg::CMD_REFRESH ||
     in_item.cmd == lcdseq_pkg::CMD_WRITE)) |=> !out_valid)
    else $error("result from an item that makes none");

  // finish events carry a zero byte, init finish is in command mode
  a_finish_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.event_kind != lcdseq_pkg::EV_BYTE) |->
    (out_item.tx_byte == 8'h00 &&
     (out_item.event_kind != lcdseq_pkg::EV_INIT_DONE || !out_item.register_select)))
    else $error("bad finish event fields");

endmodule

bind lcd_init_and_refresh_sequencer_core lcdseq_checker u_lcdseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives init ticks, refresh events and message store writes into the LCD
// sequencer, tracks its expected byte stream in a local copy of the
// sequencer state and compares every result item as it is taken.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MSG_LEN  = 24;
  localparam int INIT_LEN = 10;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [79:0] INIT_SEQ   = 80'h39_39_15_55_6E_72_38_0F_01_06;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lcdseq_pkg::in_item_t  in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lcdseq_pkg::out_item_t out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data  = 8'h00;

  lcd_init_and_refresh_sequencer_core #(
    .MSG_LEN (MSG_LEN),
    .INIT_LEN(INIT_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the sequencer
  logic [7:0] clear_cmd;
  logic       seq_init;
  logic       seq_busy;
  int         init_pos;
  int         msg_pos;
  logic       sel_level;
  logic [7:0] msg_store [MSG_LEN];

  lcdseq_pkg::out_item_t expected_results [$];
  int                    error_count = 0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;

  task automatic reset_shadow();
    string txt;
    txt       = " CW  - 20.0 C    0.2 RPS";
    clear_cmd = lcdseq_pkg::CLEAR_CMD_RST;
    seq_init  = 1'b1;
    seq_busy  = 1'b1;
    init_pos  = 0;
    msg_pos   = 0;
    sel_level = 1'b0;
    for (int i = 0; i < MSG_LEN; i++) msg_store[i] = txt[i];
    msg_store[0] = clear_cmd;
  endtask

  task automatic advance_sequencer(input lcdseq_pkg::in_item_t it);
    lcdseq_pkg::out_item_t r;
    r = '0;
    case (it.cmd)
      lcdseq_pkg::CMD_TICK: begin
        if (seq_busy && it.link_ready) begin
          r.event_kind = lcdseq_pkg::EV_BYTE;
          r.tx_byte    = 8'h00;
          if (seq_init) begin
            if (init_pos < INIT_LEN) begin
              r.tx_byte = INIT_SEQ[79 - 8 * init_pos -: 8];
              init_pos++;
            end else begin
              seq_init     = 1'b0;
              seq_busy     = 1'b0;
              r.event_kind = lcdseq_pkg::EV_INIT_DONE;
            end
          end else if (msg_pos < MSG_LEN) begin
            // register select switches to data from entry one on
            if (msg_pos == 1) sel_level = 1'b1;
            r.tx_byte = msg_store[msg_pos];
            msg_pos++;
          end else begin
            msg_pos      = 0;
            seq_busy     = 1'b0;
            r.event_kind = lcdseq_pkg::EV_FRAME_DONE;
          end
          r.register_select = sel_level;
          expected_results.push_back(r);
        end
      end
      lcdseq_pkg::CMD_REFRESH: begin
        if (!seq_busy) begin
          sel_level = 1'b0;
          seq_busy  = 1'b1;
        end
      end
      lcdseq_pkg::CMD_WRITE: begin
        if (it.byte_index < MSG_LEN) msg_store[it.byte_index] = it.byte_value;
        msg_store[0] = clear_cmd;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    lcdseq_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) advance_sequencer(in_item);
      if (cfg_valid && cfg_ready) clear_cmd = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing pending", 0, int'(out_item));
        end else begin
          want = expected_results.pop_front();
          if (out_item.event_kind != want.event_kind)
            report_mismatch("event_kind", int'(want.event_kind),
                            int'(out_item.event_kind));
          if (out_item.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", int'(want.tx_byte), int'(out_item.tx_byte));
          if (out_item.register_select != want.register_select)
            report_mismatch("register_select", int'(want.register_select),
                            int'(out_item.register_select));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic lcdseq_pkg::in_item_t make_item(input logic [1:0] cmd,
                                                     input logic ready,
                                                     input logic [4:0] idx,
                                                     input logic [7:0] val);
    lcdseq_pkg::in_item_t it;
    it.cmd        = cmd;
    it.link_ready = ready;
    it.byte_index = idx;
    it.byte_value = val;
    return it;
  endfunction

  // mostly ticks with a ready link, some refreshes and writes, a little noise
  function automatic lcdseq_pkg::in_item_t random_item();
    lcdseq_pkg::in_item_t it;
    int                   pick;
    it   = lcdseq_pkg::in_item_t'(16'($urandom));
    pick = $urandom_range(99);
    if (pick < 70) begin
      it.cmd        = lcdseq_pkg::CMD_TICK;
      it.link_ready = ($urandom_range(99) < 85);
    end else if (pick < 80) begin
      it.cmd = lcdseq_pkg::CMD_REFRESH;
    end else if (pick < 97) begin
      it.cmd = lcdseq_pkg::CMD_WRITE;
      if ($urandom_range(9) != 0) it.byte_index = 5'($urandom_range(MSG_LEN - 1));
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input lcdseq_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // in_valid is expected low here
  task automatic wait_drained(input int extra);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_clear_command(input logic [7:0] value);
    in_valid <= 1'b0;
    wait_drained(4);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_init_sequence();
    write_clear_command(8'hFF);
    send_item(make_item(lcdseq_pkg::CMD_TICK, 1'b0, 5'd31, 8'hFF));
    send_item(make_item(lcdseq_pkg::CMD_REFRESH, 1'b1, 5'd0, 8'h00));
    send_item(make_item(CMD_UNUSED, 1'b1, 5'd31, 8'hFF));
    for (int i = 0; i <= INIT_LEN; i++)
      send_item(make_item(lcdseq_pkg::CMD_TICK, 1'b1, 5'd0, 8'h00));
    // idle now, a tick does nothing
    send_item(make_item(lcdseq_pkg::CMD_TICK, 1'b1, 5'd31, 8'hFF));
  endtask

  task automatic test_store_edges();
    write_clear_command(8'h00);
    send_item(make_item(lcdseq_pkg::CMD_WRITE, 1'b0, 5'd0, 8'hAB));
    send_item(make_item(lcdseq_pkg::CMD_WRITE, 1'b1, 5'd23, 8'hFF));
    send_item(make_item(lcdseq_pkg::CMD_WRITE, 1'b0, 5'd24, 8'h55));
    send_item(make_item(lcdseq_pkg::CMD_WRITE, 1'b1, 5'd31, 8'h00));
    send_item(make_item(lcdseq_pkg::CMD_WRITE, 1'b0, 5'd1, 8'h00));
    send_item(make_item(lcdseq_pkg::CMD_REFRESH, 1'b0, 5'd31, 8'hFF));
    // already busy, second refresh is dropped
    send_item(make_item(lcdseq_pkg::CMD_REFRESH, 1'b1, 5'd0, 8'h00));
    send_item(make_item(lcdseq_pkg::CMD_TICK, 1'b0, 5'd0, 8'h00));
    send_item(make_item(lcdseq_pkg::CMD_TICK, 1'b1, 5'd31, 8'hFF));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 35; rx_idle_pct = 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_clear_command((phase == 1) ? 8'hFF : 8'($urandom_range(255)));
      for (int n = 0; n < 333; n++) begin
        if (phase == 0 && n == 150) begin
          in_valid <= 1'b0;
          wait_drained(0);
        end
        send_item(random_item());
      end
    end
  endtask

  initial begin
    reset_shadow();
    tx_idle_pct = 35;
    rx_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_init_sequence();
    test_store_edges();
    test_random_traffic();
    in_valid <= 1'b0;
    wait_drained(10);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lcdseq_pkg.sv
sv/lcd_init_and_refresh_sequencer_core.sv
sv/lcdseq_checker.sv
test/testbench.sv
